// ===== src/fts_pkg.sv =====
// Shared types and constants of the floppy transfer sequencer.
// No dependencies; used by the channel interfaces and the top module.
`default_nettype none

package fts_pkg;

  localparam int QueueDepth = 4;
  localparam int QidxW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam int BlkW   = 9;
  localparam int WordsW = 16;
  localparam int RetryW = 4;
  localparam int LsecW  = BlkW + 2;
  localparam int SecW   = 5;
  localparam int TrkW   = 7;
  localparam int KindW  = 2;

  localparam logic [BlkW-1:0]   MaxBlocksRst = 9'd500;
  localparam logic [RetryW-1:0] RetryLimRst  = 4'd10;

  localparam logic [WordsW-1:0] WordsPerSector = 16'd64;
  localparam int                SectorsPerTrk = 26;
  localparam logic [TrkW-1:0]   WrapTrack     = 7'd77;

  // floor(L / 26) = (L * Recip) >> RecipShift for every L below 2^LsecW
  localparam int                RecipW     = 12;
  localparam logic [RecipW-1:0] Recip      = 12'd2521;
  localparam int                RecipShift = 16;

  localparam logic [KindW-1:0] KindCmd    = 2'd0;
  localparam logic [KindW-1:0] KindFinish = 2'd1;
  localparam logic [KindW-1:0] KindReject = 2'd2;

  localparam logic FuncRequest    = 1'b0;
  localparam logic FuncCompletion = 1'b1;

  localparam logic RegMaxBlocks  = 1'b0;
  localparam logic RegRetryLimit = 1'b1;
  localparam int   PaddrW        = 3;

  typedef struct packed {
    logic              func;
    logic [BlkW-1:0]   block_number;
    logic [WordsW-1:0] word_count;
    logic              is_read;
    logic              drive_unit;
    logic              error_flag;
  } in_word_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             read_op;
    logic             unit;
    logic [SecW-1:0]  sector;
    logic [TrkW-1:0]  track;
    logic             request_error;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic [BlkW-1:0]   blk;
    logic [WordsW-1:0] words;
    logic              rd;
    logic              un;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

`default_nettype wire

// ===== src/fts_ifs.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on fts_pkg for the payload types.
`default_nettype none

interface fts_in_if;
  logic               valid;
  logic               ready;
  fts_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fts_out_if;
  logic               valid;
  logic               ready;
  fts_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/fts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fts_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/floppy_transfer_sequencer_top.sv =====
// Floppy transfer sequencer: queue in fts_ram; needs fts_pkg, fts_ifs and fts_ram.
// A command passes S_DIV (quotient register quot_q) and S_CMD into the output register;
// a finish or rejection passes msg_q and S_MSG; a finish with a next command goes
// S_MSG, S_LOAD (queue RAM read), S_DIV, S_CMD. Words are taken only in S_IDLE, so not
// while a word is in progress; S_MSG and S_CMD wait for a free output register.
// Reset clears control state, loads max_blocks 500 and retry_limit 10; RAM not cleared.
`default_nettype none

module floppy_transfer_sequencer_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  fts_in_if.sink                            in_i,
  fts_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fts_pkg::PaddrW-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MSG  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CMD  = 3'd4;

  localparam int QidxW = fts_pkg::QidxW;
  localparam int CntW  = fts_pkg::CntW;

  logic [2:0]                      state_q, state_d;
  logic [fts_pkg::BlkW-1:0]        max_blocks_q, max_blocks_d;
  logic [fts_pkg::RetryW-1:0]      retry_limit_q, retry_limit_d;
  logic [QidxW-1:0]                head_q, head_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic                            busy_q, busy_d;
  logic [1:0]                      sib_q, sib_d;
  logic [fts_pkg::RetryW-1:0]      retry_q, retry_d;
  logic [fts_pkg::BlkW-1:0]        blk_q, blk_d;
  logic [fts_pkg::WordsW-1:0]      words_q, words_d;
  logic                            failed_q, failed_d;
  logic                            hrd_q, hrd_d;
  logic                            hun_q, hun_d;
  logic [fts_pkg::TrkW-1:0]        quot_q, quot_d;
  fts_pkg::out_word_t              msg_q, msg_d;
  logic                            load_pend_q, load_pend_d;
  logic                            out_valid_q, out_valid_d;
  fts_pkg::out_word_t              out_data_q, out_data_d;

  logic                            in_fire;
  logic                            slot_free;
  logic                            cfg_write;
  logic                            ram_we, ram_re;
  logic [QidxW-1:0]                ram_waddr, ram_raddr;
  fts_pkg::entry_t                 ram_wdata, ram_rdata;
  logic [CntW:0]                   tail_sum, head_sum;
  logic [QidxW-1:0]                tail_idx, head_next;
  logic [CntW-1:0]                 cnt_next;
  logic [fts_pkg::RetryW:0]        retry_inc;
  logic                            fail_eff;
  logic [fts_pkg::LsecW-1:0]       lsec;
  logic [fts_pkg::LsecW+fts_pkg::RecipW-1:0] prod;
  logic [fts_pkg::LsecW-1:0]       rem_full;
  logic [6:0]                      rem3;
  logic [6:0]                      smod;
  logic [fts_pkg::TrkW-1:0]        trk;

  fts_ram #(
    .Width (fts_pkg::EntryW),
    .Depth (fts_pkg::QueueDepth)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && (state_q == S_IDLE);
  assign slot_free   = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      fts_pkg::RegMaxBlocks:  prdata = {{(32 - fts_pkg::BlkW){1'b0}}, max_blocks_q};
      fts_pkg::RegRetryLimit: prdata = {{(32 - fts_pkg::RetryW){1'b0}}, retry_limit_q};
      default:                prdata = 32'd0;
    endcase
  end

  always_comb begin
    tail_sum = (CntW + 1)'(head_q) + (CntW + 1)'(count_q);
    if (tail_sum >= (CntW + 1)'(fts_pkg::QueueDepth)) begin
      tail_sum = tail_sum - (CntW + 1)'(fts_pkg::QueueDepth);
    end
    tail_idx = tail_sum[QidxW-1:0];
    head_sum = (CntW + 1)'(head_q) + (CntW + 1)'(1);
    if (head_sum >= (CntW + 1)'(fts_pkg::QueueDepth)) begin
      head_sum = head_sum - (CntW + 1)'(fts_pkg::QueueDepth);
    end
    head_next = head_sum[QidxW-1:0];
    cnt_next  = (count_q != '0) ? count_q - CntW'(1) : '0;
    retry_inc = {1'b0, retry_q} + (fts_pkg::RetryW + 1)'(1);
    fail_eff  = failed_q || in_i.data.error_flag;

    lsec     = {blk_q, sib_q};
    prod     = lsec * fts_pkg::Recip;
    rem_full = lsec - fts_pkg::LsecW'(quot_q) * fts_pkg::LsecW'(fts_pkg::SectorsPerTrk);
    rem3     = 7'(rem_full[4:0]) * 7'd3;
    if (rem3 >= 7'(2 * fts_pkg::SectorsPerTrk)) begin
      smod = rem3 - 7'(2 * fts_pkg::SectorsPerTrk);
    end else if (rem3 >= 7'(fts_pkg::SectorsPerTrk)) begin
      smod = rem3 - 7'(fts_pkg::SectorsPerTrk);
    end else begin
      smod = rem3;
    end
    trk = quot_q + fts_pkg::TrkW'(1);
    if (trk == fts_pkg::WrapTrack) begin
      trk = '0;
    end
  end

  always_comb begin
    state_d       = state_q;
    max_blocks_d  = max_blocks_q;
    retry_limit_d = retry_limit_q;
    head_d        = head_q;
    count_d       = count_q;
    busy_d        = busy_q;
    sib_d         = sib_q;
    retry_d       = retry_q;
    blk_d         = blk_q;
    words_d       = words_q;
    failed_d      = failed_q;
    hrd_d         = hrd_q;
    hun_d         = hun_q;
    quot_d        = quot_q;
    msg_d         = msg_q;
    load_pend_d   = load_pend_q;
    out_data_d    = out_data_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    ram_we        = 1'b0;
    ram_waddr     = tail_idx;
    ram_wdata     = '{blk: in_i.data.block_number, words: in_i.data.word_count,
                      rd: in_i.data.is_read, un: in_i.data.drive_unit};
    ram_re        = 1'b0;
    ram_raddr     = head_next;

    if (cfg_write) begin
      case (paddr[2])
        fts_pkg::RegMaxBlocks:  max_blocks_d  = pwdata[fts_pkg::BlkW-1:0];
        fts_pkg::RegRetryLimit: retry_limit_d = pwdata[fts_pkg::RetryW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.data.func == fts_pkg::FuncRequest) begin
            msg_d = '{kind: fts_pkg::KindFinish, read_op: in_i.data.is_read,
                      unit: in_i.data.drive_unit, sector: '0, track: '0,
                      request_error: 1'b1, last: 1'b1};
            load_pend_d = 1'b0;
            if (in_i.data.block_number >= max_blocks_q) begin
              state_d = S_MSG;
            end else if (count_q >= CntW'(fts_pkg::QueueDepth)) begin
              msg_d.kind          = fts_pkg::KindReject;
              msg_d.request_error = 1'b0;
              state_d             = S_MSG;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CntW'(1);
              if (!busy_q) begin
                if (count_q == '0) begin
                  blk_d    = in_i.data.block_number;
                  words_d  = in_i.data.word_count;
                  sib_d    = 2'd0;
                  retry_d  = '0;
                  failed_d = 1'b0;
                  hrd_d    = in_i.data.is_read;
                  hun_d    = in_i.data.drive_unit;
                end
                state_d = S_DIV;
              end
            end
          end else if (busy_q) begin
            busy_d = 1'b0;
            if (in_i.data.error_flag && (retry_inc <= {1'b0, retry_limit_q})) begin
              retry_d = retry_inc[fts_pkg::RetryW-1:0];
              state_d = S_DIV;
            end else begin
              retry_d = '0;
              if (words_q <= fts_pkg::WordsPerSector) begin
                msg_d = '{kind: fts_pkg::KindFinish, read_op: hrd_q, unit: hun_q,
                          sector: '0, track: '0, request_error: fail_eff,
                          last: (cnt_next == '0)};
                load_pend_d = (cnt_next != '0);
                ram_re      = (cnt_next != '0);
                head_d      = head_next;
                count_d     = cnt_next;
                sib_d       = 2'd0;
                failed_d    = 1'b0;
                state_d     = S_MSG;
              end else begin
                words_d  = words_q - fts_pkg::WordsPerSector;
                sib_d    = sib_q + 2'd1;
                if (sib_q == 2'd3) begin
                  blk_d = blk_q + fts_pkg::BlkW'(1);
                end
                failed_d = fail_eff;
                state_d  = S_DIV;
              end
            end
          end
        end
      end
      S_MSG: begin
        if (slot_free) begin
          out_data_d  = msg_q;
          out_valid_d = 1'b1;
          state_d     = load_pend_q ? S_LOAD : S_IDLE;
        end
      end
      S_LOAD: begin
        blk_d    = ram_rdata.blk;
        words_d  = ram_rdata.words;
        hrd_d    = ram_rdata.rd;
        hun_d    = ram_rdata.un;
        sib_d    = 2'd0;
        retry_d  = '0;
        failed_d = 1'b0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        quot_d  = prod[fts_pkg::RecipShift +: fts_pkg::TrkW];
        state_d = S_CMD;
      end
      S_CMD: begin
        if (slot_free) begin
          out_data_d = '{kind: fts_pkg::KindCmd, read_op: hrd_q, unit: hun_q,
                         sector: fts_pkg::SecW'(smod) + fts_pkg::SecW'(1), track: trk,
                         request_error: 1'b0, last: 1'b1};
          out_valid_d = 1'b1;
          busy_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      max_blocks_q  <= fts_pkg::MaxBlocksRst;
      retry_limit_q <= fts_pkg::RetryLimRst;
      head_q        <= '0;
      count_q       <= '0;
      busy_q        <= 1'b0;
      sib_q         <= 2'd0;
      retry_q       <= '0;
      blk_q         <= '0;
      words_q       <= '0;
      failed_q      <= 1'b0;
      hrd_q         <= 1'b0;
      hun_q         <= 1'b0;
      quot_q        <= '0;
      msg_q         <= '0;
      load_pend_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      state_q       <= state_d;
      max_blocks_q  <= max_blocks_d;
      retry_limit_q <= retry_limit_d;
      head_q        <= head_d;
      count_q       <= count_d;
      busy_q        <= busy_d;
      sib_q         <= sib_d;
      retry_q       <= retry_d;
      blk_q         <= blk_d;
      words_q       <= words_d;
      failed_q      <= failed_d;
      hrd_q         <= hrd_d;
      hun_q         <= hun_d;
      quot_q        <= quot_d;
      msg_q         <= msg_d;
      load_pend_q   <= load_pend_d;
      out_valid_q   <= out_valid_d;
      out_data_q    <= out_data_d;
    end
  end

endmodule

`default_nettype wire
